>>> hdl/ccfr_pkg.sv
package ccfr_pkg;

    localparam int MAX_PAYLOAD = 64;
    localparam int CNT_W       = $clog2(MAX_PAYLOAD + 3);
    localparam int HEAD_N      = 5;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] START_BYTE = 8'h3A;
    localparam logic [7:0] CR_BYTE    = 8'h0D;
    localparam logic [7:0] LF_BYTE    = 8'h0A;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_SUM = 2'd1,
        ST_SHORT   = 2'd2,
        ST_LONG    = 2'd3
    } t_status;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       block_end;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  frame_status;
        logic [7:0]  dest_address;
        logic [7:0]  frame_kind;
        logic [7:0]  third_byte;
        logic [7:0]  fourth_byte;
        logic [7:0]  fifth_byte;
        logic [6:0]  payload_length;
        logic [15:0] received_sum;
    } t_out_item;

    typedef struct packed {
        logic [CNT_W-1:0]           len;
        logic [HEAD_N-1:0][7:0]     head;
        logic [15:0]                recv;
        logic [15:0]                sum;
    } t_frame_rec;

endpackage

>>> hdl/ccfr_front.sv
module ccfr_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  ccfr_pkg::t_in_item  i_data,
    output logic                o_stall,
    input  logic                i_full,
    output logic                o_push,
    output ccfr_pkg::t_frame_rec o_rec
);
    import ccfr_pkg::*;

    logic                   r_in_frame, n_in_frame;
    logic                   r_last_cr, n_last_cr;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic [15:0]            r_old_sum, n_old_sum;
    logic [2:0][7:0]        r_recent, n_recent;
    logic [HEAD_N-1:0][7:0] r_head, n_head;
    logic                   accept;

    assign o_stall = i_full;
    assign accept  = i_valid && !i_full;

    always_comb begin
        n_in_frame = r_in_frame;
        n_last_cr  = r_last_cr;
        n_cnt      = r_cnt;
        n_old_sum  = r_old_sum;
        n_recent   = r_recent;
        n_head     = r_head;
        o_push     = 1'b0;
        o_rec.len  = r_cnt - CNT_W'(1);
        o_rec.head = r_head;
        o_rec.recv = {r_recent[1], r_recent[2]};
        o_rec.sum  = r_old_sum;
        if (accept) begin
            if (i_data.rx_byte == START_BYTE) begin
                n_in_frame = 1'b1;
                n_last_cr  = 1'b0;
                n_cnt      = '0;
                n_old_sum  = '0;
                n_recent   = '0;
                n_head     = '0;
            end else if (r_in_frame) begin
                if (i_data.rx_byte == LF_BYTE && r_last_cr) begin
                    o_push     = 1'b1;
                    n_in_frame = 1'b0;
                    n_last_cr  = 1'b0;
                    n_cnt      = '0;
                    n_old_sum  = '0;
                    n_recent   = '0;
                    n_head     = '0;
                end else begin
                    if (r_cnt < CNT_W'(HEAD_N)) begin
                        n_head[r_cnt[2:0]] = i_data.rx_byte;
                    end
                    if (r_cnt < CNT_W'(MAX_PAYLOAD + 2)) begin
                        n_cnt = r_cnt + CNT_W'(1);
                    end
                    n_old_sum   = r_old_sum + {8'h00, r_recent[2]};
                    n_recent[2] = r_recent[1];
                    n_recent[1] = r_recent[0];
                    n_recent[0] = i_data.rx_byte;
                    n_last_cr   = (i_data.rx_byte == CR_BYTE);
                end
            end
            if (i_data.block_end) begin
                n_in_frame = 1'b0;
                n_last_cr  = 1'b0;
                n_cnt      = '0;
                n_old_sum  = '0;
                n_recent   = '0;
                n_head     = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_last_cr  <= 1'b0;
            r_cnt      <= '0;
            r_old_sum  <= '0;
            r_recent   <= '0;
            r_head     <= '0;
        end else begin
            r_in_frame <= n_in_frame;
            r_last_cr  <= n_last_cr;
            r_cnt      <= n_cnt;
            r_old_sum  <= n_old_sum;
            r_recent   <= n_recent;
            r_head     <= n_head;
        end
    end

    a_push_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (r_in_frame && r_last_cr && r_cnt != '0))
        else $error("Frame pushed without an open frame ending in CR.");

    a_block_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_data.block_end) |=> (!r_in_frame && r_cnt == '0))
        else $error("Frame state survived the end of a block.");

endmodule

>>> hdl/ccfr_queue.sv
module ccfr_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  ccfr_pkg::t_frame_rec i_rec,
    output logic                 o_full,
    output logic                 o_avail,
    input  logic                 i_pop,
    output ccfr_pkg::t_frame_rec o_rec
);
    import ccfr_pkg::*;

    t_frame_rec          r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr, r_rd;
    logic [QPTR_W:0]     r_count;

    assign o_full  = (r_count == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign o_avail = (r_count != '0);
    assign o_rec   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + QPTR_W'(1);
            end
            r_count <= r_count + (QPTR_W + 1)'(i_push) - (QPTR_W + 1)'(i_pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full) && !(i_pop && !o_avail))
        else $error("Frame queue overflow or underflow.");

endmodule

>>> hdl/ccfr_back.sv
module ccfr_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_avail,
    input  ccfr_pkg::t_frame_rec i_rec,
    output logic                 o_pop,
    output logic                 o_valid,
    output ccfr_pkg::t_out_item  o_data,
    input  logic                 i_stall
);
    import ccfr_pkg::*;

    logic      r_valid;
    t_out_item r_out, n_out;
    t_status   status;

    assign o_pop   = i_avail && (!r_valid || !i_stall);
    assign o_valid = r_valid;
    assign o_data  = r_out;

    always_comb begin
        if (i_rec.len > CNT_W'(MAX_PAYLOAD)) begin
            status = ST_LONG;
        end else if (i_rec.len < CNT_W'(3)) begin
            status = ST_SHORT;
        end else if (i_rec.sum != i_rec.recv) begin
            status = ST_BAD_SUM;
        end else begin
            status = ST_OK;
        end
    end

    always_comb begin
        logic [HEAD_N-1:0][7:0] head;
        for (int i = 0; i < HEAD_N; i++) begin
            head[i] = (CNT_W'(i) < i_rec.len) ? i_rec.head[i] : 8'h00;
        end
        n_out.frame_status   = status;
        n_out.dest_address   = head[0];
        n_out.frame_kind     = head[1];
        n_out.third_byte     = head[2];
        n_out.fourth_byte    = head[3];
        n_out.fifth_byte     = head[4];
        n_out.payload_length = 7'(i_rec.len);
        n_out.received_sum   = i_rec.recv;
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    a_ok_has_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_out.frame_status == ST_OK) |-> (r_out.payload_length >= 7'd3))
        else $error("Frame marked good with a payload shorter than three bytes.");

endmodule

>>> hdl/colon_crlf_frame_receiver.sv
// With the queue empty and the output free, the record of a frame is written into the queue at the
// edge that accepts the closing LF, and the result item is then presented from the output register.
// Throughput: one input item per cycle while the two-entry frame queue has room.
// The queue sits before the output register; every input byte stalls while it holds two
// frames, which happens only after the output side has been stalled, and still holds during
// the cycle in which the output side resumes.
// Reset is synchronous and active low; it clears all frame state, the queue and output valid.
module colon_crlf_frame_receiver (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  ccfr_pkg::t_in_item  i_data,
    output logic                o_stall,
    output logic                o_valid,
    output ccfr_pkg::t_out_item o_data,
    input  logic                i_stall
);
    import ccfr_pkg::*;

    logic       push, full, avail, pop;
    t_frame_rec push_rec, pop_rec;

    ccfr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_stall (o_stall),
        .i_full  (full),
        .o_push  (push),
        .o_rec   (push_rec)
    );

    ccfr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (push_rec),
        .o_full  (full),
        .o_avail (avail),
        .i_pop   (pop),
        .o_rec   (pop_rec)
    );

    ccfr_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_avail (avail),
        .i_rec   (pop_rec),
        .o_pop   (pop),
        .o_valid (o_valid),
        .o_data  (o_data),
        .i_stall (i_stall)
    );

endmodule
